// ----- src/r2y_pkg.sv -----
// Shared types, constants and the sample arithmetic of the RGB to YUV 4:2:0 writer.
package r2y_pkg;

  localparam int unsigned ADDR_W     = 25;
  localparam int unsigned CFG_DIM_W  = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SUM_W      = 27;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 13'd1280;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 13'd720;
  localparam logic                 LAYOUT_RST = 1'b0;

  // Layout codes.
  localparam logic LAYOUT_YV12 = 1'b0;
  localparam logic LAYOUT_NV12 = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LAYOUT = 2'd2
  } cfg_reg_e;

  // Q16 coefficients, rounded to nearest, and the chroma offset.
  localparam logic signed [SUM_W-1:0] C_YR   = 27'sd19595;
  localparam logic signed [SUM_W-1:0] C_YG   = 27'sd38470;
  localparam logic signed [SUM_W-1:0] C_YB   = 27'sd7471;
  localparam logic signed [SUM_W-1:0] C_UR   = -27'sd11076;
  localparam logic signed [SUM_W-1:0] C_UG   = -27'sd21692;
  localparam logic signed [SUM_W-1:0] C_UB   = 27'sd32768;
  localparam logic signed [SUM_W-1:0] C_VR   = 27'sd32768;
  localparam logic signed [SUM_W-1:0] C_VG   = -27'sd27460;
  localparam logic signed [SUM_W-1:0] C_VB   = -27'sd5308;
  localparam logic signed [SUM_W-1:0] C_BIAS = 27'sd8388608;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        byte_value;
    logic              pixel_done;
    logic              frame_done;
  } write_t;

  // Frame geometry worked out once per configuration write.
  typedef struct packed {
    logic [ADDR_W-1:0] ystride;
    logic [ADDR_W-1:0] cstep;
    logic [ADDR_W-1:0] ysize;
    logic [ADDR_W-1:0] c_second;
  } geom_t;

  // The writes of one pixel: the luma write, then two chroma writes if triple is set.
  typedef struct packed {
    write_t [2:0] wr;
    logic         triple;
  } group_t;

  // Truncate a Q16 sum toward zero and saturate it to a byte.
  function automatic logic [7:0] q16_sat(input logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s <= 0) begin
      res = 8'd0;
    end else if (s[SUM_W-1:16] > 11'd255) begin
      res = 8'd255;
    end else begin
      res = s[23:16];
    end
    return res;
  endfunction

endpackage

// ----- src/r2y_stream_if.sv -----
// Valid/ready channel that carries one payload per transaction.
interface r2y_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/rgba_to_planar_yuv420_writer.sv -----
// Top level of the streaming RGB to planar YUV 4:2:0 (YV12 or NV12) byte writer.
// Pixels arrive in raster order on pix_i and each one turns into byte writes on wr_o: a luma
// write, followed at even column and even row by two chroma writes (V then U for YV12, U then
// V for NV12). The first write of a pixel leaves from the result register, which takes it from the
// capture register. The single write port carries one byte per cycle while the sink is ready, so a
// chroma pixel holds the port for three writes where any other pixel makes one. A two-entry
// stage (capture register and result register) lets the next pixel be taken while writes wait.
// Row addresses are kept as running sums, so no multiplier sits in the pixel path; the plane
// sizes are worked out in the cycle of each configuration write, and any such write restarts
// the frame at column and row zero. Write configuration only while the block is idle.
module rgba_to_planar_yuv420_writer #(
  parameter int MAX_DIM = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [r2y_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [r2y_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  r2y_stream_if.sink                       pix_i,
  r2y_stream_if.source                     wr_o
);
  import r2y_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned STR_W = DIM_W + 1;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  function automatic geom_t derive(input logic [CFG_DIM_W-1:0] rw,
                                   input logic [CFG_DIM_W-1:0] rh,
                                   input logic mode);
    logic [DIM_W-1:0] w, h;
    logic [STR_W-1:0] ys, cs;
    logic [31:0]      ysz, cprod;
    geom_t            g;
    w     = eff_dim(rw);
    h     = eff_dim(rh);
    ys    = STR_W'(((32'(w) + 32'd15) >> 4) << 4);
    cs    = STR_W'((((32'(ys) >> 1) + 32'd15) >> 4) << 4);
    ysz   = 32'(ys) * 32'(h);
    cprod = 32'(cs) * 32'(h);
    g.ystride  = ADDR_W'(ys);
    g.cstep    = (mode == LAYOUT_NV12) ? ADDR_W'(ys) : ADDR_W'(cs);
    g.ysize    = ADDR_W'(ysz);
    g.c_second = (mode == LAYOUT_NV12) ? ADDR_W'(1) : ADDR_W'(cprod >> 1);
    return g;
  endfunction

  localparam geom_t GEOM_RST = derive(WIDTH_RST, HEIGHT_RST, LAYOUT_RST);

  // Configuration and derived geometry.
  logic [CFG_DIM_W-1:0] width_q, width_d, height_q, height_d;
  logic                 layout_q, layout_d;
  logic                 restart;
  geom_t                geom_q, geom_d;
  logic [DIM_W-1:0]     eff_w, eff_h;

  // Position in the frame and running row addresses.
  logic [CNT_W-1:0]  col_q, col_d, row_q, row_d;
  logic [ADDR_W-1:0] yrow_q, yrow_d, crow_q, crow_d;
  logic              col_end, row_end;

  // Capture stage.
  logic              a_valid_q, a_valid_d;
  pixel_t            a_pix_q;
  logic [ADDR_W-1:0] a_yaddr_q, a_caddr_q;
  logic              a_chroma_q, a_last_q;
  logic              accept, take;
  logic              r2y_emit_take;

  logic [7:0]        y_val, u_val, v_val;
  group_t            grp;
  logic [ADDR_W-1:0] c_col_off;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    layout_d = layout_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH: begin
          width_d = CFG_DIM_W'(cfg_data_i);
          restart = 1'b1;
        end
        REG_HEIGHT: begin
          height_d = CFG_DIM_W'(cfg_data_i);
          restart  = 1'b1;
        end
        REG_LAYOUT: begin
          layout_d = cfg_data_i[0];
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end
    geom_d = derive(width_d, height_d, layout_d);
  end

  assign eff_w   = eff_dim(width_q);
  assign eff_h   = eff_dim(height_q);
  assign col_end = (col_q == CNT_W'(eff_w - DIM_W'(1)));
  assign row_end = (row_q == CNT_W'(eff_h - DIM_W'(1)));

  assign take         = r2y_emit_take;
  assign pix_i.ready  = !a_valid_q || take;
  assign accept       = pix_i.valid && pix_i.ready;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    yrow_d = yrow_q;
    crow_d = crow_q;
    if (restart) begin
      col_d  = '0;
      row_d  = '0;
      yrow_d = '0;
      crow_d = '0;
    end else if (accept) begin
      if (!col_end) begin
        col_d = col_q + CNT_W'(1);
      end else begin
        col_d = '0;
        if (row_end) begin
          row_d  = '0;
          yrow_d = '0;
          crow_d = '0;
        end else begin
          row_d  = row_q + CNT_W'(1);
          yrow_d = yrow_q + geom_q.ystride;
          // The chroma row moves on after each odd luma row.
          if (row_q[0]) begin
            crow_d = crow_q + geom_q.cstep;
          end
        end
      end
    end
  end

  assign a_valid_d = accept || (a_valid_q && !take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      layout_q  <= LAYOUT_RST;
      geom_q    <= GEOM_RST;
      col_q     <= '0;
      row_q     <= '0;
      yrow_q    <= '0;
      crow_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      layout_q  <= layout_d;
      geom_q    <= geom_d;
      col_q     <= col_d;
      row_q     <= row_d;
      yrow_q    <= yrow_d;
      crow_q    <= crow_d;
      a_valid_q <= a_valid_d;
    end
  end

  // NV12 pairs sit at the even column itself; YV12 planes use half the column.
  assign c_col_off = (layout_q == LAYOUT_NV12) ? ADDR_W'(col_q) : ADDR_W'(col_q >> 1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q    <= pix_i.payload;
      a_yaddr_q  <= yrow_q + ADDR_W'(col_q);
      a_caddr_q  <= geom_q.ysize + crow_q + c_col_off;
      a_chroma_q <= !col_q[0] && !row_q[0];
      a_last_q   <= col_end && row_end;
    end
  end

  r2y_csc u_csc (
    .pix_i (a_pix_q),
    .y_o   (y_val),
    .u_o   (u_val),
    .v_o   (v_val)
  );

  always_comb begin
    grp.triple                = a_chroma_q;
    grp.wr[0].byte_address    = a_yaddr_q;
    grp.wr[0].byte_value      = y_val;
    grp.wr[0].pixel_done      = !a_chroma_q;
    grp.wr[0].frame_done      = !a_chroma_q && a_last_q;
    grp.wr[1].byte_address    = a_caddr_q;
    grp.wr[1].byte_value      = (layout_q == LAYOUT_NV12) ? u_val : v_val;
    grp.wr[1].pixel_done      = 1'b0;
    grp.wr[1].frame_done      = 1'b0;
    grp.wr[2].byte_address    = a_caddr_q + geom_q.c_second;
    grp.wr[2].byte_value      = (layout_q == LAYOUT_NV12) ? v_val : u_val;
    grp.wr[2].pixel_done      = 1'b1;
    grp.wr[2].frame_done      = a_last_q;
  end

  r2y_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (a_valid_q),
    .group_i      (grp),
    .take_o       (r2y_emit_take),
    .wr_o         (wr_o)
  );

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(eff_w))
    else $error("column counter ran past the frame width");

  a_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < 32'(eff_h))
    else $error("row counter ran past the frame height");

  a_row_bases_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q == '0 |-> yrow_q == '0 && crow_q == '0)
    else $error("row address sums not cleared at the top of the frame");

endmodule

// ----- src/r2y_csc.sv -----
// BT.601 colour conversion of one pixel into clamped Y, U and V bytes.
module r2y_csc (
  input  r2y_pkg::pixel_t pix_i,
  output logic [7:0]      y_o,
  output logic [7:0]      u_o,
  output logic [7:0]      v_o
);
  import r2y_pkg::*;

  logic signed [SUM_W-1:0] r_s, g_s, b_s;
  logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;

  assign r_s = {19'd0, pix_i.red};
  assign g_s = {19'd0, pix_i.green};
  assign b_s = {19'd0, pix_i.blue};

  assign y_sum = C_YR * r_s + C_YG * g_s + C_YB * b_s;
  assign u_sum = C_UR * r_s + C_UG * g_s + C_UB * b_s + C_BIAS;
  assign v_sum = C_VR * r_s + C_VG * g_s + C_VB * b_s + C_BIAS;

  assign y_o = q16_sat(y_sum);
  assign u_o = q16_sat(u_sum);
  assign v_o = q16_sat(v_sum);

endmodule

// ----- src/r2y_emit.sv -----
// Result register that holds the writes of one pixel and hands them out one per cycle while wr_o is ready.
module r2y_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  r2y_pkg::group_t   group_i,
  output logic              take_o,
  r2y_stream_if.source      wr_o
);
  import r2y_pkg::*;

  logic         busy_q, busy_d;
  logic [1:0]   idx_q, idx_d;
  logic         triple_q;
  write_t [2:0] ent_q;
  logic         fire, last;

  assign last   = !triple_q || (idx_q == 2'd2);
  assign fire   = busy_q && wr_o.ready;
  assign take_o = !busy_q || (fire && last);

  assign wr_o.valid   = busy_q;
  assign wr_o.payload = ent_q[idx_q];

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (take_o && load_valid_i) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (fire && last) begin
      busy_d = 1'b0;
      idx_d  = 2'd0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && load_valid_i) begin
      ent_q    <= group_i.wr;
      triple_q <= group_i.triple;
    end
  end

  a_idx_in_triple: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> busy_q && triple_q)
    else $error("write index advanced outside a three-write group");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && load_valid_i |=> busy_q && idx_q == 2'd0)
    else $error("loaded group does not start at its first write");

endmodule
